// ----- rtl/sha_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared types, round constants and round functions of the stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

   localparam int QueueDepth = 4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } core_state_type;

   function automatic logic [31:0] round_const(input logic [5:0] idx);
      logic [31:0] k;
      begin
         unique case (idx)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
         endcase
         return k;
      end
   endfunction

   function automatic logic [31:0] init_hash(input logic [2:0] idx);
      logic [31:0] h;
      begin
         unique case (idx)
            3'd0: h = 32'h6a09e667;
            3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372;
            3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f;
            3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            3'd7: h = 32'h5be0cd19;
            default: h = 32'h0;
         endcase
         return h;
      end
   endfunction

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage
`default_nettype wire

// ----- rtl/sha_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 input queue
// Short first-in first-out queue between the accepting front and the core.
// ----------------------------------------------------------------------------
module sha_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  wire sha_pkg::item_type push_item,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output sha_pkg::item_type      pop_item
);

   localparam int AddrWidth = $clog2(sha_pkg::QueueDepth);

   sha_pkg::item_type       slot_ff [sha_pkg::QueueDepth];
   logic [AddrWidth-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AddrWidth-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AddrWidth:0]      count_ff, count_in;
   logic                    do_push, do_pop;

   assign push_ready = (count_ff != (AddrWidth+1)'(sha_pkg::QueueDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff == (AddrWidth+1)'(sha_pkg::QueueDepth) |=> !(count_ff == '0))
      else $error("queue count collapsed from full");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not follow push");
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> !do_pop)
      else $error("pop from empty queue");

endmodule
`default_nettype wire

// ----- rtl/sha_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 compression core
// Gathers bytes into a block, pads the message and runs one round per cycle.
// ----------------------------------------------------------------------------
module sha_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   output logic                   item_ready,
   input  wire sha_pkg::item_type item,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [31:0]            out_word,
   output logic [2:0]             out_index,
   output logic                   out_final
);

   sha_pkg::core_state_type state_ff, state_in;

   logic [31:0] buf_ff [16];
   logic [5:0]  fill_ff, fill_in;
   logic [60:0] count_ff, count_in;
   logic [31:0] h_ff [8];
   logic [31:0] v_ff [8];
   logic [31:0] w_ff [16];
   logic [5:0]  round_ff, round_in;
   logic [2:0]  emit_ff, emit_in;
   logic        pad_ff, pad_in;     // padding pass pending
   logic        last_ff, last_in;   // current block is the final one
   logic        endm_ff, endm_in;   // end item waiting for padding

   logic        take;
   logic        wr_en;
   logic [5:0]  wr_addr;
   logic [7:0]  wr_data;
   logic        load_go;
   logic [31:0] w_new, t1, t2;
   logic [31:0] s0, s1, big0, big1, ch, maj;
   logic [63:0] bit_len;

   assign bit_len = {count_ff, 3'b000};
   assign take    = item_valid && item_ready;

   always_comb begin
      s0   = sha_pkg::ror(w_ff[1], 7) ^ sha_pkg::ror(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1   = sha_pkg::ror(w_ff[14], 17) ^ sha_pkg::ror(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_new = w_ff[0] + s0 + w_ff[9] + s1;
      big1 = sha_pkg::ror(v_ff[4], 6) ^ sha_pkg::ror(v_ff[4], 11) ^ sha_pkg::ror(v_ff[4], 25);
      ch   = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1   = v_ff[7] + big1 + ch + sha_pkg::round_const(round_ff) + w_ff[0];
      big0 = sha_pkg::ror(v_ff[0], 2) ^ sha_pkg::ror(v_ff[0], 13) ^ sha_pkg::ror(v_ff[0], 22);
      maj  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2   = big0 + maj;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sha_pkg::ST_IDLE: begin
            if (take) begin
               if (item.byte_present && fill_ff == 6'd63) begin
                  state_in = sha_pkg::ST_LOAD;
               end else if (item.end_of_message) begin
                  state_in = sha_pkg::ST_LOAD;
               end
            end else if (endm_ff) begin
               state_in = sha_pkg::ST_LOAD;
            end
         end
         sha_pkg::ST_LOAD: begin
            if (load_go) begin
               state_in = sha_pkg::ST_ROUND;
            end
         end
         sha_pkg::ST_ROUND: begin
            if (round_ff == 6'd63) begin
               state_in = sha_pkg::ST_FOLD;
            end
         end
         sha_pkg::ST_FOLD: begin
            if (last_ff) begin
               state_in = sha_pkg::ST_EMIT;
            end else if (pad_ff) begin
               state_in = sha_pkg::ST_LOAD;
            end else begin
               state_in = sha_pkg::ST_IDLE;
            end
         end
         sha_pkg::ST_EMIT: begin
            if (out_ready && emit_ff == 3'd7) begin
               state_in = sha_pkg::ST_IDLE;
            end
         end
         default: state_in = sha_pkg::ST_IDLE;
      endcase
   end

   // Outputs and datapath control.
   always_comb begin
      item_ready = (state_ff == sha_pkg::ST_IDLE) && !endm_ff;
      out_valid  = (state_ff == sha_pkg::ST_EMIT);
      out_word   = h_ff[emit_ff];
      out_index  = emit_ff;
      out_final  = (emit_ff == 3'd7);
      fill_in    = fill_ff;
      count_in   = count_ff;
      round_in   = round_ff;
      emit_in    = emit_ff;
      pad_in     = pad_ff;
      last_in    = last_ff;
      endm_in    = endm_ff;
      wr_en      = 1'b0;
      wr_addr    = fill_ff;
      wr_data    = item.data_byte;
      load_go    = 1'b0;
      unique case (state_ff)
         sha_pkg::ST_IDLE: begin
            if (take) begin
               if (item.byte_present) begin
                  wr_en    = 1'b1;
                  fill_in  = fill_ff + 1'b1;
                  count_in = count_ff + 1'b1;
               end
               if (item.end_of_message) begin
                  endm_in = 1'b1;
               end
               if (item.end_of_message && !(item.byte_present && fill_ff == 6'd63)) begin
                  endm_in = 1'b0;
                  pad_in  = 1'b1;
               end
            end else if (endm_ff) begin
               endm_in = 1'b0;
               pad_in  = 1'b1;
            end
         end
         sha_pkg::ST_LOAD: begin
            round_in = '0;
            if (pad_ff) begin
               // Padding: one byte per cycle from fill_ff to the block end.
               wr_en = 1'b1;
               if (fill_ff >= 6'd56 && last_ff) begin
                  wr_data = bit_len[8*(63-fill_ff) +: 8];
               end else begin
                  wr_data = 8'h00;
               end
               fill_in = fill_ff + 1'b1;
               if (fill_ff == 6'd63) begin
                  load_go = 1'b1;
                  if (last_ff) begin
                     pad_in = 1'b0;
                  end
               end
               if (!last_ff && fill_ff == 6'd55) begin
                  last_in = 1'b1;
               end
            end else begin
               load_go = 1'b1;
            end
         end
         sha_pkg::ST_ROUND: begin
            round_in = round_ff + 1'b1;
         end
         sha_pkg::ST_FOLD: begin
            emit_in = '0;
         end
         sha_pkg::ST_EMIT: begin
            if (out_ready) begin
               emit_in = emit_ff + 1'b1;
               if (emit_ff == 3'd7) begin
                  fill_in  = '0;
                  count_in = '0;
                  last_in  = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Marker byte: the first padding write of a message is 0x80.
   logic mark_ff, mark_in;
   logic [7:0] pad_byte;
   always_comb begin
      mark_in  = mark_ff;
      pad_byte = wr_data;
      if (state_ff == sha_pkg::ST_LOAD && pad_ff && mark_ff) begin
         pad_byte = 8'h80;
         mark_in  = 1'b0;
      end
      if (state_ff == sha_pkg::ST_EMIT && out_ready && emit_ff == 3'd7) begin
         mark_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha_pkg::ST_IDLE;
         fill_ff  <= '0;
         count_ff <= '0;
         round_ff <= '0;
         emit_ff  <= '0;
         pad_ff   <= 1'b0;
         last_ff  <= 1'b0;
         endm_ff  <= 1'b0;
         mark_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
         round_ff <= round_in;
         emit_ff  <= emit_in;
         pad_ff   <= pad_in;
         endm_ff  <= endm_in;
         mark_ff  <= mark_in;
         if (state_ff == sha_pkg::ST_IDLE && pad_in && !pad_ff) begin
            last_ff <= (fill_in < 6'd56);
         end else begin
            last_ff <= last_in;
         end
      end
   end

   // Bytes land big-endian in sixteen block words.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         buf_ff[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <=
            (state_ff == sha_pkg::ST_LOAD) ? pad_byte : wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= sha_pkg::init_hash(3'(i));
         end
      end else if (state_ff == sha_pkg::ST_FOLD) begin
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= h_ff[i] + v_ff[i];
         end
      end else if (state_ff == sha_pkg::ST_EMIT && out_ready && emit_ff == 3'd7) begin
         for (int i = 0; i < 8; i++) begin
            h_ff[i] <= sha_pkg::init_hash(3'(i));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == sha_pkg::ST_LOAD && load_go) begin
         for (int i = 0; i < 8; i++) begin
            v_ff[i] <= h_ff[i];
         end
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= buf_ff[i];
         end
         if (pad_ff) begin
            w_ff[15] <= {buf_ff[15][31:8], pad_byte};
         end else begin
            w_ff[15] <= buf_ff[15];
         end
      end else if (state_ff == sha_pkg::ST_ROUND) begin
         for (int i = 0; i < 15; i++) begin
            w_ff[i] <= w_ff[i+1];
         end
         w_ff[15] <= w_new;
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

   a_round_run: assert property (@(posedge clock) disable iff (reset)
      state_ff == sha_pkg::ST_ROUND && round_ff != 6'd63 |=> state_ff == sha_pkg::ST_ROUND)
      else $error("round sequence broke early");
   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(emit_ff))
      else $error("digest word dropped under stall");
   a_idle_only: assert property (@(posedge clock) disable iff (reset)
      item_ready |-> state_ff == sha_pkg::ST_IDLE)
      else $error("item taken while busy");

endmodule
`default_nettype wire

// ----- rtl/sha256_stream_hasher.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Hashes a byte stream and returns the eight digest words of each message.
// ----------------------------------------------------------------------------
// The req_ channel carries one byte per transfer; req_tuser says whether the
// byte is present and req_tlast ends the message. A transfer lands in a
// four-entry queue; the core takes one queued transfer per cycle while it is
// idle. A 64th byte starts a block: the load state, 64 rounds and the fold
// state, during which the core takes nothing. The end of a message adds
// padding, written one byte per cycle up to the block end, then one or two
// compressions. The digest leaves on rsp_ as eight transfers, word 0
// first, rsp_tuser holding the word index and rsp_tlast set on word 7.
// A stalled rsp_tready holds the current word; the queue keeps taking
// input until it is full. Reset empties the queue and restores the
// initial hash values.
// ----------------------------------------------------------------------------
module sha256_stream_hasher (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte
   input  wire logic        req_tuser,   // byte_present
   input  wire logic        req_tlast,   // end_of_message
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // digest_word
   output logic [2:0]       rsp_tuser,   // word_index
   output logic             rsp_tlast    // final_word
);

   sha_pkg::item_type in_item, q_item;
   logic              q_valid, q_ready;

   assign in_item.data_byte      = req_tdata;
   assign in_item.byte_present   = req_tuser;
   assign in_item.end_of_message = req_tlast;

   sha_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_item  (in_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_item   (q_item)
   );

   sha_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_valid),
      .item_ready (q_ready),
      .item       (q_item),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_word   (rsp_tdata),
      .out_index  (rsp_tuser),
      .out_final  (rsp_tlast)
   );

endmodule
`default_nettype wire
